// ===== hdl/mhde_pkg.sv =====
// Package for the MPEG header duration estimator.
// Holds widths, bitrate tables, the divisor lookup and the controller/datapath structs.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mhde_pkg;

    localparam int FSIZE_W = 32;
    localparam int DUR_W = 23;
    localparam int DVS_W = 16;
    localparam int DIV_STEPS = FSIZE_W;
    localparam int CNT_W = $clog2(DIV_STEPS);

    localparam logic [7:0] SYNC_FIRST = 8'hFF;
    localparam logic [7:0] SYNC_MASK = 8'hE0;
    localparam logic [FSIZE_W-1:0] MIN_FILE_BYTES = 32'd128;

    // Eight bits per byte over 1000 bits per kilobit reduces to one over 125.
    localparam logic [DVS_W-1:0] KBPS_SCALE = 16'd125;

    localparam logic [1:0] VER_MPEG1 = 2'd3;
    localparam logic [1:0] VER_RESERVED = 2'd1;
    localparam logic [1:0] LAYER_RESERVED = 2'd0;
    localparam logic [1:0] LAYER_III = 2'd1;
    localparam logic [1:0] LAYER_II = 2'd2;
    localparam logic [3:0] IDX_FREE = 4'd0;
    localparam logic [3:0] IDX_BAD = 4'd15;

    localparam logic [8:0] RATE_V1_L3 [16] = '{
        9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
    localparam logic [8:0] RATE_V1_L2 [16] = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
    localparam logic [8:0] RATE_V1_L1 [16] = '{
        9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
    localparam logic [8:0] RATE_V2 [16] = '{
        9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

    typedef struct packed {
        logic take;
        logic div_load;
        logic div_step;
        logic div_last;
    } ctl_cmd_t;

    typedef struct packed {
        logic header_hit;
        logic out_busy;
    } dp_status_t;

    // Returns the bitrate in kbit/s times 125, or zero for reserved fields or index 0 or 15.
    function automatic logic [DVS_W-1:0] rate_divisor(input logic [7:0] hdr,
                                                      input logic [7:0] br);
        logic [1:0] version;
        logic [1:0] layer;
        logic [3:0] idx;
        logic [8:0] kbps;
        version = hdr[4:3];
        layer = hdr[2:1];
        idx = br[7:4];
        if (version == VER_MPEG1)
        begin
            if (layer == LAYER_III)
            begin
                kbps = RATE_V1_L3[idx];
            end
            else if (layer == LAYER_II)
            begin
                kbps = RATE_V1_L2[idx];
            end
            else
            begin
                kbps = RATE_V1_L1[idx];
            end
        end
        else
        begin
            kbps = RATE_V2[idx];
        end
        if (version == VER_RESERVED || layer == LAYER_RESERVED || idx == IDX_FREE
            || idx == IDX_BAD)
        begin
            kbps = 9'd0;
        end
        return DVS_W'(DVS_W'(kbps) * KBPS_SCALE);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mpeg_header_duration_estimator.sv =====
// The scanner takes one file byte per cycle until it answers. After a valid frame header,
// the duration comes from a radix-2 restoring divider that forms one quotient bit per
// cycle; input stalls while it runs, until the result word appears. Input also stalls
// while an answer for an earlier file waits at the output. Bytes that follow an answer
// in the same file pass at one per cycle. Top level; uses mhde_pkg, mhde_ctrl, mhde_datapath.
`timescale 1ns / 1ps
`default_nettype none

module mpeg_header_duration_estimator
    import mhde_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [FSIZE_W-1:0] file_size,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         data_byte,
    input  wire logic               last_byte,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [DUR_W-1:0]        duration_seconds,
    output logic                    header_found
);

    ctl_cmd_t   cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    mhde_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    mhde_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_data         (file_size),
        .data_byte        (data_byte),
        .last_byte        (last_byte),
        .cmd              (cmd),
        .status           (status),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .duration_seconds (duration_seconds),
        .header_found     (header_found)
    );

endmodule

`default_nettype wire

// ===== hdl/mhde_ctrl.sv =====
// Controller of the MPEG header duration estimator.
// Sequences byte scanning and the iterative divider; uses mhde_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mhde_ctrl
    import mhde_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire dp_status_t status,
    output ctl_cmd_t        cmd
);

    typedef enum logic [1:0] {
        ST_SCAN = 2'b01,
        ST_DIV  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_comb
    begin
        in_stall = (state_reg != ST_SCAN) || status.out_busy;
        cmd.take = in_valid && !in_stall;
        cmd.div_load = cmd.take && status.header_hit;
        cmd.div_step = (state_reg == ST_DIV);
        cmd.div_last = (state_reg == ST_DIV) && (cnt_reg == CNT_W'(DIV_STEPS - 1));
        state_next = state_reg;
        cnt_next = cnt_reg;
        unique case (state_reg)
            ST_SCAN:
            begin
                cnt_next = '0;
                if (cmd.div_load)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cmd.div_last)
                begin
                    state_next = ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_SCAN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SCAN;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mhde_datapath.sv =====
// Datapath of the MPEG header duration estimator.
// Holds the file size, the sync scanner, the restoring divider and the result register.
// Uses mhde_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mhde_datapath
    import mhde_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    input  wire logic [FSIZE_W-1:0] cfg_data,
    input  wire logic [7:0]         data_byte,
    input  wire logic               last_byte,
    input  wire ctl_cmd_t           cmd,
    output dp_status_t              status,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [DUR_W-1:0]        duration_seconds,
    output logic                    header_found
);

    typedef enum logic [3:0] {
        PH_HUNT    = 4'b0001,
        PH_SYNC2   = 4'b0010,
        PH_BITRATE = 4'b0100,
        PH_FOURTH  = 4'b1000
    } phase_t;

    logic [FSIZE_W-1:0] file_size_reg;
    phase_t             phase_reg;
    phase_t             phase_next;
    logic [FSIZE_W-1:0] pos_reg;
    logic [FSIZE_W-1:0] pos_next;
    logic [FSIZE_W-1:0] pos_adv;
    logic [7:0]         hdr_reg;
    logic [7:0]         hdr_next;
    logic [7:0]         br_reg;
    logic [7:0]         br_next;
    logic               answered_reg;
    logic               answered_next;
    logic               emit_zero;
    logic               small_file;
    logic [DVS_W-1:0]   divisor;

    logic [DVS_W-1:0]   dvs_reg;
    logic [DVS_W-1:0]   rem_reg;
    logic [FSIZE_W-1:0] quo_reg;
    logic [DVS_W+1:0]   diff;
    logic               fits;
    logic [DVS_W-1:0]   rem_step;
    logic [FSIZE_W-1:0] quo_step;

    logic               out_valid_reg;
    logic [DUR_W-1:0]   dur_reg;
    logic               found_reg;

    assign small_file = (file_size_reg < MIN_FILE_BYTES);
    assign divisor = rate_divisor(hdr_reg, br_reg);
    assign pos_adv = (pos_reg == '1) ? pos_reg : pos_reg + 1'b1;

    assign status.header_hit = !answered_reg && !small_file && (phase_reg == PH_FOURTH)
                               && (divisor != '0);
    assign status.out_busy = out_valid_reg && !answered_reg;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next = pos_reg;
        hdr_next = hdr_reg;
        br_next = br_reg;
        answered_next = answered_reg;
        emit_zero = 1'b0;
        if (cmd.take)
        begin
            if (!answered_reg)
            begin
                if (small_file)
                begin
                    emit_zero = 1'b1;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_HUNT:
                        begin
                            if (pos_reg >= file_size_reg - 1'b1)
                            begin
                                emit_zero = 1'b1;
                            end
                            else
                            begin
                                pos_next = pos_adv;
                                if (data_byte == SYNC_FIRST)
                                begin
                                    phase_next = PH_SYNC2;
                                end
                            end
                        end
                        PH_SYNC2:
                        begin
                            pos_next = pos_adv;
                            if ((data_byte & SYNC_MASK) == SYNC_MASK)
                            begin
                                hdr_next = data_byte;
                                phase_next = PH_BITRATE;
                            end
                            else
                            begin
                                phase_next = PH_HUNT;
                            end
                        end
                        PH_BITRATE:
                        begin
                            pos_next = pos_adv;
                            br_next = data_byte;
                            phase_next = PH_FOURTH;
                        end
                        PH_FOURTH:
                        begin
                            pos_next = pos_adv;
                            phase_next = PH_HUNT;
                        end
                        default:
                        begin
                            phase_next = PH_HUNT;
                        end
                    endcase
                end
                if (last_byte && !status.header_hit)
                begin
                    emit_zero = 1'b1;
                end
                if (emit_zero || status.header_hit)
                begin
                    answered_next = 1'b1;
                end
            end
            if (last_byte)
            begin
                phase_next = PH_HUNT;
                pos_next = '0;
                answered_next = 1'b0;
            end
        end
    end

    // One quotient bit per cycle.
    always_comb
    begin
        diff = {1'b0, rem_reg, quo_reg[FSIZE_W-1]} - {2'b00, dvs_reg};
        fits = !diff[DVS_W+1];
        rem_step = fits ? diff[DVS_W-1:0] : {rem_reg[DVS_W-2:0], quo_reg[FSIZE_W-1]};
        quo_step = {quo_reg[FSIZE_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_size_reg <= '0;
            phase_reg <= PH_HUNT;
            pos_reg <= '0;
            answered_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                file_size_reg <= cfg_data;
            end
            phase_reg <= phase_next;
            pos_reg <= pos_next;
            answered_reg <= answered_next;
            if (emit_zero || cmd.div_last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg <= hdr_next;
        br_reg <= br_next;
        if (cmd.div_load)
        begin
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= file_size_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_step;
            quo_reg <= quo_step;
        end
        if (emit_zero)
        begin
            dur_reg <= '0;
            found_reg <= 1'b0;
        end
        else if (cmd.div_last)
        begin
            dur_reg <= quo_step[DUR_W-1:0];
            found_reg <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign duration_seconds = dur_reg;
    assign header_found = found_reg;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench for mpeg_header_duration_estimator: streams file bytes, changes the file size
// between runs, and checks every answer word against a scoreboard that tracks the scan.
// Depends on mhde_pkg and the DUT sources.
`timescale 1ns / 1ps

module testbench;

    import mhde_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int BYTES_PER_PHASE = 160;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;
    localparam logic [7:0] SYNC_TOP = 8'hE0;
    localparam logic [31:0] SMALL_FILE = 32'd128;
    localparam logic [1:0] VERSION_1 = 2'd3;
    localparam logic [1:0] VERSION_RSVD = 2'd1;
    localparam logic [1:0] LAYER_NONE = 2'd0;
    localparam logic [1:0] LAYER_3 = 2'd1;
    localparam logic [1:0] LAYER_2 = 2'd2;
    localparam logic [3:0] RATE_IDX_FREE = 4'd0;
    localparam logic [3:0] RATE_IDX_BAD = 4'd15;

    typedef enum logic [1:0] {SCAN_HUNT, SCAN_SYNC2, SCAN_RATE, SCAN_TAIL} scan_phase_t;

    typedef struct packed {
        logic [DUR_W-1:0] secs;
        logic             found;
    } answer_t;

    class duration_board;
        logic [31:0] size_reg;
        scan_phase_t phase;
        logic [31:0] pos;
        logic [7:0]  hdr_byte;
        logic [7:0]  rate_byte;
        bit          answered;
        bit          made;
        answer_t     due[$];
        int          errors;
        int          sent_bytes;
        int unsigned kbps_v1_l3 [16] = '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192,
                                         224, 256, 320, 0};
        int unsigned kbps_v1_l2 [16] = '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224,
                                         256, 320, 384, 0};
        int unsigned kbps_v1_l1 [16] = '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320,
                                         352, 384, 416, 448, 0};
        int unsigned kbps_v2 [16] = '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128,
                                      144, 160, 0};

        function new();
            size_reg = '0;
            errors = 0;
            sent_bytes = 0;
            rearm();
        endfunction

        function void rearm();
            phase = SCAN_HUNT;
            pos = '0;
            hdr_byte = '0;
            rate_byte = '0;
            answered = 0;
        endfunction

        function void set_size(logic [31:0] v);
            size_reg = v;
        endfunction

        function int pending();
            return due.size();
        endfunction

        function void post(logic [DUR_W-1:0] secs, logic found);
            answer_t a;
            a.secs = secs;
            a.found = found;
            due.push_back(a);
            answered = 1;
            made = 1;
        endfunction

        function void step_pos();
            if (pos != 32'hFFFFFFFF)
            begin
                pos = pos + 1;
            end
        endfunction

        function int unsigned header_kbps();
            logic [1:0] version;
            logic [1:0] layer;
            logic [3:0] idx;
            version = hdr_byte[4:3];
            layer = hdr_byte[2:1];
            idx = rate_byte[7:4];
            if (version == VERSION_RSVD || layer == LAYER_NONE || idx == RATE_IDX_FREE
                || idx == RATE_IDX_BAD)
            begin
                return 0;
            end
            if (version != VERSION_1)
            begin
                return kbps_v2[idx];
            end
            if (layer == LAYER_3)
            begin
                return kbps_v1_l3[idx];
            end
            if (layer == LAYER_2)
            begin
                return kbps_v1_l2[idx];
            end
            return kbps_v1_l1[idx];
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            int unsigned kbps;
            logic [63:0] secs;
            made = 0;
            sent_bytes++;
            if (!answered)
            begin
                if (size_reg < SMALL_FILE)
                begin
                    post('0, 1'b0);
                end
                else
                begin
                    case (phase)
                        SCAN_HUNT:
                        begin
                            if (pos >= size_reg - 32'd1)
                            begin
                                post('0, 1'b0);
                            end
                            else
                            begin
                                step_pos();
                                if (b == SYNC_BYTE)
                                begin
                                    phase = SCAN_SYNC2;
                                end
                            end
                        end
                        SCAN_SYNC2:
                        begin
                            step_pos();
                            if ((b & SYNC_TOP) == SYNC_TOP)
                            begin
                                hdr_byte = b;
                                phase = SCAN_RATE;
                            end
                            else
                            begin
                                phase = SCAN_HUNT;
                            end
                        end
                        SCAN_RATE:
                        begin
                            step_pos();
                            rate_byte = b;
                            phase = SCAN_TAIL;
                        end
                        default:
                        begin
                            step_pos();
                            phase = SCAN_HUNT;
                            kbps = header_kbps();
                            if (kbps != 0)
                            begin
                                secs = (64'(size_reg) * 64'd8) / (64'(kbps) * 64'd1000);
                                post(secs[DUR_W-1:0], 1'b1);
                            end
                        end
                    endcase
                end
                if (last && !made)
                begin
                    post('0, 1'b0);
                end
            end
            if (last)
            begin
                rearm();
            end
        endfunction

        function void check_answer(logic [DUR_W-1:0] secs, logic found);
            answer_t want;
            if (due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("Unexpected word: duration %0d found %0d", secs, found);
                end
                return;
            end
            want = due.pop_front();
            if (secs !== want.secs || found !== want.found)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("Mismatch: duration %0d (expected %0d), found %0d (expected %0d)",
                             secs, want.secs, found, want.found);
                end
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [FSIZE_W-1:0] file_size;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         data_byte;
    logic               last_byte;
    logic               out_valid;
    logic               out_stall;
    logic [DUR_W-1:0]   duration_seconds;
    logic               header_found;

    duration_board board = new();
    bit hold_off_req = 0;
    int cycles = 0;

    mpeg_header_duration_estimator DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .file_size        (file_size),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .data_byte        (data_byte),
        .last_byte        (last_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .duration_seconds (duration_seconds),
        .header_found     (header_found)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[mpeg_header_duration_estimator] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            board.check_answer(duration_seconds, header_found);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] noise_byte(bit no_sync);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (no_sync && b == SYNC_BYTE)
        begin
            b = 8'h00;
        end
        return b;
    endfunction

    initial
    begin
        int len;
        bit level;
        int r;
        out_stall = 1'b0;
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 0;
                level = 1'b1;
                len = HOLD_OFF_CYCLES;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 20)
                begin
                    level = 1'b0;
                    len = $urandom_range(50, 200);
                end
                else if (r < 60)
                begin
                    level = 1'b1;
                    len = pick_gap() + 1;
                end
                else
                begin
                    level = 1'b0;
                    len = $urandom_range(1, 8);
                end
            end
            repeat (len)
            begin
                @(negedge clk);
                out_stall <= level;
            end
        end
    end

    task automatic send_word(input logic [7:0] b, input logic last, input bit quiet);
        int gap;
        gap = quiet ? 0 : pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        board.note_byte(b, last);
    endtask

    task automatic play(input logic [7:0] q[$], input bit quiet);
        for (int i = 0; i < q.size(); i++)
        begin
            send_word(q[i], i == q.size() - 1, quiet);
        end
    endtask

    task automatic write_size(input logic [31:0] v);
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        file_size <= v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        board.set_size(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_file(input bit long_ok);
        logic [7:0] q[$];
        int kind;
        bit quiet;
        kind = $urandom_range(0, 99);
        quiet = ($urandom_range(0, 3) == 0);
        if (kind < 65)
        begin
            repeat ($urandom_range(0, 12)) q.push_back(noise_byte(0));
            q.push_back(SYNC_BYTE);
            q.push_back(SYNC_TOP | 8'($urandom_range(0, 31)));
            q.push_back(8'($urandom_range(0, 255)));
            q.push_back(8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 10)) q.push_back(noise_byte(0));
        end
        else if (kind < 80)
        begin
            q.push_back(SYNC_BYTE);
            if ($urandom_range(0, 1))
            begin
                q.push_back(8'($urandom_range(0, 8'hDF)));
            end
            else
            begin
                q.push_back(SYNC_BYTE);
                q.push_back(SYNC_TOP | 8'($urandom_range(0, 31)));
            end
            repeat ($urandom_range(0, 3)) q.push_back(noise_byte(0));
        end
        else if (kind < 90 || !long_ok)
        begin
            repeat ($urandom_range(1, 30)) q.push_back(noise_byte(0));
        end
        else
        begin
            repeat (int'(board.size_reg) + $urandom_range(0, 20) - 4)
                q.push_back(noise_byte(1));
        end
        play(q, quiet);
    endtask

    initial
    begin
        logic [31:0] sz;
        int goal;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        file_size = '0;
        in_valid = 1'b0;
        data_byte = '0;
        last_byte = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_size(32'd0);
        play('{8'h00}, 0);
        play('{8'hFF, 8'h12}, 0);
        write_size(32'hFFFFFFFF);
        play('{8'hFF, 8'hF3, 8'hE4, 8'h00}, 0);
        play('{8'hFF, 8'hE2, 8'h10, 8'h00}, 0);
        play('{8'hFF, 8'hEA, 8'h50, 8'h55}, 1);
        write_size(32'd128);
        play('{8'hFF, 8'hF9, 8'h90, 8'h00, 8'h01}, 0);
        play('{8'hFF, 8'hFD, 8'hE0, 8'h00, 8'h7F}, 1);

        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: sz = 32'd128;
                1: sz = 32'($urandom_range(0, 127));
                2: sz = 32'($urandom_range(129, 400));
                3: sz = 32'($urandom_range(1000, 2000000));
                4: sz = 32'hFFFFFFFF;
                5: sz = 32'($urandom_range(129, 400));
                6: sz = $urandom();
                7: sz = 32'd400;
                8: sz = 32'd127;
                default: sz = 32'($urandom_range(130, 300));
            endcase
            write_size(sz);
            if (ph == 0 || ph == 5)
            begin
                hold_off_req = 1;
            end
            goal = board.sent_bytes + BYTES_PER_PHASE;
            while (board.sent_bytes < goal)
            begin
                send_random_file(sz >= SMALL_FILE && sz <= 32'd400);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES + 20) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
        begin
            $display("[mpeg_header_duration_estimator] OK");
        end
        else
        begin
            $display("[mpeg_header_duration_estimator] ERROR");
        end
        $finish;
    end

endmodule
